[rtl/srtn_pkg.sv]
`default_nettype none

package srtn_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int TICK_W      = 16;
    localparam int SWITCH_W    = 16;
    localparam int ENTRY_W     = ID_W + TICK_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] left;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PLACE,
        ST_POP
    } state_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        ptr_t r;
        if (p == '0)
        begin
            r = PTR_LAST;
        end
        else
        begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/srtn_req_if.sv]
`default_nettype none

interface srtn_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [srtn_pkg::ID_W-1:0]   job_id;
    logic [srtn_pkg::TICK_W-1:0] burst_ticks;

    modport source (output valid, action, job_id, burst_ticks, input ready);
    modport sink   (input valid, action, job_id, burst_ticks, output ready);
endinterface

`default_nettype wire

[rtl/srtn_rsp_if.sv]
`default_nettype none

interface srtn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          running_valid;
    logic [srtn_pkg::ID_W-1:0]      running_job;
    logic [srtn_pkg::TICK_W-1:0]    running_left;
    logic                          finished_valid;
    logic [srtn_pkg::ID_W-1:0]      finished_job;
    logic                          preempted;
    logic [srtn_pkg::SWITCH_W-1:0]  switch_count;
    logic                          queue_full;

    modport source (output valid, running_valid, running_job, running_left, finished_valid,
                    finished_job, preempted, switch_count, queue_full, input ready);
    modport sink   (input valid, running_valid, running_job, running_left, finished_valid,
                    finished_job, preempted, switch_count, queue_full, output ready);
endinterface

`default_nettype wire

[rtl/srtn_preemptive_scheduler.sv]
`default_nettype none

// Channel | Dir | Fields                                                   | Handshake
// req     | in  | action, job_id, burst_ticks                              | valid/ready
// rsp     | out | running_valid/job/left, finished_valid/job, preempted,   | valid/ready
//         |     | switch_count, queue_full                                 |
// Tick: ST_POP loads a waiting job from the queue RAM when the head finishes.
// Arrival: done in ST_IDLE if the queue is full or it lands at the head or behind a lone
// head; otherwise ST_WALK walks queued entries from the tail (one compare per RAM read),
// and ST_PLACE follows when it lands directly behind the head.
// Reset empties the queue at once; RAM contents are don't-care. req.ready stays low
// while an item is in work or a result is stalled on rsp.

module srtn_preemptive_scheduler (
    input wire logic     clk,
    input wire logic     rst_n,
    srtn_req_if.sink     req,
    srtn_rsp_if.source   rsp
);

    srtn_pkg::state_t                    state_reg, state_next;
    logic [srtn_pkg::CNT_W-1:0]          count_reg, count_next;
    srtn_pkg::ptr_t                      front_reg, front_next;
    srtn_pkg::ptr_t                      tail_reg, tail_next;
    srtn_pkg::ptr_t                      walk_reg, walk_next;
    logic [srtn_pkg::ID_W-1:0]           head_id_reg, head_id_next;
    logic [srtn_pkg::TICK_W-1:0]         head_left_reg, head_left_next;
    logic [srtn_pkg::ID_W-1:0]           new_id_reg, new_id_next;
    logic [srtn_pkg::TICK_W-1:0]         new_left_reg, new_left_next;
    logic [srtn_pkg::SWITCH_W-1:0]       switches_reg, switches_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                run_v_reg, run_v_next;
    logic [srtn_pkg::ID_W-1:0]           run_id_reg, run_id_next;
    logic [srtn_pkg::TICK_W-1:0]         run_left_reg, run_left_next;
    logic                                fin_v_reg, fin_v_next;
    logic [srtn_pkg::ID_W-1:0]           fin_id_reg, fin_id_next;
    logic                                pre_reg, pre_next;
    logic                                full_reg, full_next;

    logic                                ram_we;
    srtn_pkg::ptr_t                      ram_waddr;
    srtn_pkg::entry_t                    ram_wdata;
    srtn_pkg::ptr_t                      ram_raddr;
    srtn_pkg::entry_t                    ram_rdata;

    logic                                slot_free;
    logic                                accept;
    logic                                finish;
    logic                                fin_v;
    logic                                pre;
    logic                                full;
    logic [srtn_pkg::ID_W-1:0]           fin_id;
    logic                                head_done;
    logic                                beats_head;
    logic                                walk_shift;

    assign slot_free  = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == srtn_pkg::ST_IDLE) && slot_free;
    assign accept     = req.valid && req.ready;
    assign head_done  = head_left_reg <= srtn_pkg::TICK_W'(1);
    assign beats_head = req.burst_ticks < head_left_reg;
    assign walk_shift = ram_rdata.left > new_left_reg;

    srtn_ram #(
        .WIDTH (srtn_pkg::ENTRY_W),
        .DEPTH (srtn_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == srtn_pkg::ACT_TICK)
                    begin
                        if (count_reg > srtn_pkg::CNT_W'(1) && head_done)
                        begin
                            state_next = srtn_pkg::ST_POP;
                        end
                    end
                    else if (count_reg != srtn_pkg::CNT_FULL && count_reg > srtn_pkg::CNT_W'(1)
                             && !beats_head)
                    begin
                        state_next = srtn_pkg::ST_WALK;
                    end
                end
            end
            srtn_pkg::ST_WALK:
            begin
                if (!walk_shift)
                begin
                    state_next = srtn_pkg::ST_IDLE;
                end
                else if (walk_reg == front_reg)
                begin
                    state_next = srtn_pkg::ST_PLACE;
                end
            end
            srtn_pkg::ST_PLACE:
            begin
                state_next = srtn_pkg::ST_IDLE;
            end
            srtn_pkg::ST_POP:
            begin
                state_next = srtn_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srtn_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and queue RAM control
    always_comb
    begin
        count_next     = count_reg;
        front_next     = front_reg;
        tail_next      = tail_reg;
        walk_next      = walk_reg;
        head_id_next   = head_id_reg;
        head_left_next = head_left_reg;
        new_id_next    = new_id_reg;
        new_left_next  = new_left_reg;
        switches_next  = switches_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = '{id: new_id_reg, left: new_left_reg};
        ram_raddr      = walk_reg;
        finish         = 1'b0;
        fin_v          = 1'b0;
        fin_id         = '0;
        pre            = 1'b0;
        full           = 1'b0;

        unique case (state_reg)
            srtn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    new_id_next   = req.job_id;
                    new_left_next = req.burst_ticks;
                    if (req.action == srtn_pkg::ACT_TICK)
                    begin
                        if (count_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else if (head_done)
                        begin
                            fin_v  = 1'b1;
                            fin_id = head_id_reg;
                            if (count_reg == srtn_pkg::CNT_W'(1))
                            begin
                                count_next = '0;
                                finish     = 1'b1;
                            end
                            else
                            begin
                                ram_raddr = front_reg;
                            end
                        end
                        else
                        begin
                            head_left_next = head_left_reg - srtn_pkg::TICK_W'(1);
                            finish         = 1'b1;
                        end
                    end
                    else if (count_reg == srtn_pkg::CNT_FULL)
                    begin
                        full   = 1'b1;
                        finish = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        head_id_next   = req.job_id;
                        head_left_next = req.burst_ticks;
                        count_next     = srtn_pkg::CNT_W'(1);
                        finish         = 1'b1;
                    end
                    else if (beats_head)
                    begin
                        // displaced head becomes the first waiting entry
                        ram_we         = 1'b1;
                        ram_waddr      = srtn_pkg::ptr_dec(front_reg);
                        ram_wdata      = '{id: head_id_reg, left: head_left_reg};
                        front_next     = srtn_pkg::ptr_dec(front_reg);
                        head_id_next   = req.job_id;
                        head_left_next = req.burst_ticks;
                        count_next     = count_reg + srtn_pkg::CNT_W'(1);
                        pre            = 1'b1;
                        if (switches_reg != '1)
                        begin
                            switches_next = switches_reg + srtn_pkg::SWITCH_W'(1);
                        end
                        finish = 1'b1;
                    end
                    else if (count_reg == srtn_pkg::CNT_W'(1))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        ram_wdata  = '{id: req.job_id, left: req.burst_ticks};
                        tail_next  = srtn_pkg::ptr_inc(tail_reg);
                        count_next = count_reg + srtn_pkg::CNT_W'(1);
                        finish     = 1'b1;
                    end
                    else
                    begin
                        ram_raddr = srtn_pkg::ptr_dec(tail_reg);
                        walk_next = srtn_pkg::ptr_dec(tail_reg);
                    end
                end
            end
            srtn_pkg::ST_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = srtn_pkg::ptr_inc(walk_reg);
                if (walk_shift)
                begin
                    ram_wdata = ram_rdata;
                    ram_raddr = srtn_pkg::ptr_dec(walk_reg);
                    if (walk_reg != front_reg)
                    begin
                        walk_next = srtn_pkg::ptr_dec(walk_reg);
                    end
                end
                else
                begin
                    tail_next  = srtn_pkg::ptr_inc(tail_reg);
                    count_next = count_reg + srtn_pkg::CNT_W'(1);
                    finish     = 1'b1;
                end
            end
            srtn_pkg::ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = walk_reg;
                tail_next  = srtn_pkg::ptr_inc(tail_reg);
                count_next = count_reg + srtn_pkg::CNT_W'(1);
                finish     = 1'b1;
            end
            srtn_pkg::ST_POP:
            begin
                head_id_next   = ram_rdata.id;
                head_left_next = ram_rdata.left;
                front_next     = srtn_pkg::ptr_inc(front_reg);
                count_next     = count_reg - srtn_pkg::CNT_W'(1);
                fin_v          = 1'b1;
                fin_id         = head_id_reg;
                finish         = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        run_v_next     = run_v_reg;
        run_id_next    = run_id_reg;
        run_left_next  = run_left_reg;
        fin_v_next     = fin_v_reg;
        fin_id_next    = fin_id_reg;
        pre_next       = pre_reg;
        full_next      = full_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            run_v_next     = count_next != '0;
            run_id_next    = (count_next != '0) ? head_id_next : '0;
            run_left_next  = (count_next != '0) ? head_left_next : '0;
            fin_v_next     = fin_v;
            fin_id_next    = fin_id;
            pre_next       = pre;
            full_next      = full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtn_pkg::ST_IDLE;
            count_reg     <= '0;
            front_reg     <= '0;
            tail_reg      <= '0;
            switches_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            tail_reg      <= tail_next;
            switches_reg  <= switches_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        head_id_reg   <= head_id_next;
        head_left_reg <= head_left_next;
        new_id_reg    <= new_id_next;
        new_left_reg  <= new_left_next;
        run_v_reg     <= run_v_next;
        run_id_reg    <= run_id_next;
        run_left_reg  <= run_left_next;
        fin_v_reg     <= fin_v_next;
        fin_id_reg    <= fin_id_next;
        pre_reg       <= pre_next;
        full_reg      <= full_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.running_valid  = run_v_reg;
    assign rsp.running_job    = run_id_reg;
    assign rsp.running_left   = run_left_reg;
    assign rsp.finished_valid = fin_v_reg;
    assign rsp.finished_job   = fin_id_reg;
    assign rsp.preempted      = pre_reg;
    assign rsp.switch_count   = switches_reg;
    assign rsp.queue_full     = full_reg;

endmodule

`default_nettype wire

[rtl/srtn_ram.sv]
`default_nettype none

module srtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
